### rtl/assert_macros.svh
// Assertion macros for the ARP cache RTL; included by arpc_back.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### rtl/arpc_pkg.sv
// Shared types and constants for the ARP cache.
// Used by arpc_front, arpc_back, arp_cache_table and the bench; depends on nothing.
package arpc_pkg;

   localparam int unsigned CACHE_ENTRIES_DEF = 8;
   localparam int unsigned QUEUE_DEPTH       = 2;
   localparam logic [31:0] TIMEOUT_RESET     = 32'd300;

   // Action codes of a request beat.
   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_SET    = 2'd1;
   localparam logic [1:0] ACT_SWEEP  = 2'd2;

   typedef enum logic [1:0] {
      K_LOOKUP,
      K_SET,
      K_SWEEP,
      K_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [31:0] now;
   } item_type;

   typedef struct packed {
      logic [31:0] stamp;
      logic [47:0] mac;
      logic [31:0] ip;
   } entry_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_SCAN,
      BS_FINISH
   } back_state_type;

endpackage

### rtl/arpc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the ARP cache entry store.
module arpc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

### rtl/arpc_front.sv
// Front end of the ARP cache: takes request beats, decodes the action and
// queues them for the back end. Depends on arpc_pkg.
module arpc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [31:0]        req_ip_address,
   input  logic [47:0]        req_mac_address,
   input  logic [31:0]        req_now_seconds,
   output logic               item_valid,
   output arpc_pkg::item_type item,
   input  logic               item_pop
);

   arpc_pkg::item_type slot_ff [arpc_pkg::QUEUE_DEPTH];
   arpc_pkg::item_type dec_item;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // Classify the action of the incoming beat.
   always_comb begin
      dec_item.ip  = req_ip_address;
      dec_item.mac = req_mac_address;
      dec_item.now = req_now_seconds;
      unique case (req_action)
         arpc_pkg::ACT_LOOKUP: dec_item.kind = arpc_pkg::K_LOOKUP;
         arpc_pkg::ACT_SET:    dec_item.kind = arpc_pkg::K_SET;
         arpc_pkg::ACT_SWEEP:  dec_item.kind = arpc_pkg::K_SWEEP;
         default:              dec_item.kind = arpc_pkg::K_NOP;
      endcase
   end

   // Queue bookkeeping.
   assign req_ready  = (count_ff != 2'(arpc_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(item_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage carries payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec_item;
      end
   end

endmodule

### rtl/arpc_back.sv
// Back end of the ARP cache: walks the entry store one entry per cycle,
// updates it and produces the response beat. Depends on arpc_pkg, arpc_ram, assert_macros.svh.
`include "assert_macros.svh"
module arpc_back #(
   parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  arpc_pkg::item_type item,
   output logic               item_pop,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [47:0]        rsp_mac_address_out,
   output logic [2:0]         rsp_slot_index,
   output logic               rsp_evicted_valid,
   output logic [3:0]         rsp_expired_count
);

   localparam int unsigned AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);

   arpc_pkg::back_state_type state_ff, state_in;
   arpc_pkg::item_type       work_ff;
   arpc_pkg::entry_type      rd_entry;
   logic [$bits(arpc_pkg::entry_type)-1:0] rd_bits;

   logic [31:0]              timeout_ff;
   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     p_vld_ff;
   logic [AW-1:0]            p_idx_ff;

   logic          found_ff, found_in;
   logic [AW-1:0] found_idx_ff, found_idx_in;
   logic [47:0]   found_mac_ff, found_mac_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic          min_set_ff, min_set_in;
   logic [AW-1:0] min_idx_ff, min_idx_in;
   logic [31:0]   min_stamp_ff, min_stamp_in;
   logic [3:0]    expired_ff, expired_in;

   logic          start, scan_last, finish_go, ram_we;
   logic [AW-1:0] set_slot;
   logic [31:0]   age;
   logic          cur_valid;

   logic          rsp_valid_ff;
   logic          hit_ff;
   logic [47:0]   mac_ff;
   logic [2:0]    slot_ff;
   logic          evict_ff;
   logic [3:0]    exp_ff;

   assign rd_entry  = arpc_pkg::entry_type'(rd_bits);
   assign scan_last = (cnt_ff == CW'(CACHE_ENTRIES));
   assign cur_valid = valid_ff[p_idx_ff];
   assign age       = work_ff.now - rd_entry.stamp;

   // Slot that a set writes: the match, else the first free, else the oldest.
   assign set_slot = found_ff ? found_idx_ff : (free_ff ? free_idx_ff : min_idx_ff);

   // Entry store.
   arpc_ram #(
      .WIDTH ($bits(arpc_pkg::entry_type)),
      .DEPTH (CACHE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (set_slot),
      .wdata ({work_ff.now, work_ff.mac, work_ff.ip}),
      .raddr (cnt_ff[AW-1:0]),
      .rdata (rd_bits)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arpc_pkg::BS_IDLE:   if (item_valid) state_in = arpc_pkg::BS_SCAN;
         arpc_pkg::BS_SCAN:   if (scan_last) state_in = arpc_pkg::BS_FINISH;
         arpc_pkg::BS_FINISH: if (!rsp_valid_ff || rsp_ready) state_in = arpc_pkg::BS_IDLE;
         default:             state_in = arpc_pkg::BS_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      start     = 1'b0;
      finish_go = 1'b0;
      unique case (state_ff)
         arpc_pkg::BS_IDLE:   start = item_valid;
         arpc_pkg::BS_SCAN:   ;
         arpc_pkg::BS_FINISH: finish_go = !rsp_valid_ff || rsp_ready;
         default:             ;
      endcase
   end

   assign item_pop = start;
   assign ram_we   = finish_go && (work_ff.kind == arpc_pkg::K_SET);

   // Scan counter.
   always_comb begin
      if (start) begin
         cnt_in = '0;
      end else if ((state_ff == arpc_pkg::BS_SCAN) && !scan_last) begin
         cnt_in = cnt_ff + CW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // Per-entry accumulation while the scan streams entries out of the store.
   always_comb begin
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_mac_in = found_mac_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      min_set_in   = min_set_ff;
      min_idx_in   = min_idx_ff;
      min_stamp_in = min_stamp_ff;
      expired_in   = expired_ff;
      valid_in     = valid_ff;
      if (start) begin
         found_in   = 1'b0;
         free_in    = 1'b0;
         min_set_in = 1'b0;
         expired_in = 4'd0;
      end else if (p_vld_ff) begin
         if (cur_valid && (rd_entry.ip == work_ff.ip) && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = p_idx_ff;
            found_mac_in = rd_entry.mac;
         end
         if (!cur_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = p_idx_ff;
         end
         if (!min_set_ff || (rd_entry.stamp < min_stamp_ff)) begin
            min_set_in   = 1'b1;
            min_idx_in   = p_idx_ff;
            min_stamp_in = rd_entry.stamp;
         end
         if ((work_ff.kind == arpc_pkg::K_SWEEP) && cur_valid && (age > timeout_ff)) begin
            valid_in[p_idx_ff] = 1'b0;
            if (expired_ff != 4'hF) begin
               expired_in = expired_ff + 4'd1;
            end
         end
      end
      if (ram_we) begin
         valid_in[set_slot] = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arpc_pkg::BS_IDLE;
         timeout_ff   <= arpc_pkg::TIMEOUT_RESET;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
         p_vld_ff <= (state_ff == arpc_pkg::BS_SCAN) && !scan_last;
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working item, accumulators and response payload.
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= item;
      end
      p_idx_ff     <= cnt_ff[AW-1:0];
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      found_mac_ff <= found_mac_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      min_set_ff   <= min_set_in;
      min_idx_ff   <= min_idx_in;
      min_stamp_ff <= min_stamp_in;
      expired_ff   <= expired_in;
      if (finish_go) begin
         hit_ff   <= 1'b0;
         mac_ff   <= 48'd0;
         slot_ff  <= 3'd0;
         evict_ff <= 1'b0;
         exp_ff   <= 4'd0;
         case (work_ff.kind)
            arpc_pkg::K_LOOKUP: begin
               hit_ff <= found_ff;
               if (found_ff) begin
                  mac_ff  <= found_mac_ff;
                  slot_ff <= 3'(found_idx_ff);
               end
            end
            arpc_pkg::K_SET: begin
               hit_ff   <= found_ff;
               slot_ff  <= 3'(set_slot);
               evict_ff <= !found_ff && !free_ff;
            end
            arpc_pkg::K_SWEEP: exp_ff <= expired_ff;
            default: ;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_mac_address_out = mac_ff;
   assign rsp_slot_index      = slot_ff;
   assign rsp_evicted_valid   = evict_ff;
   assign rsp_expired_count   = exp_ff;

   `ASSERT_AT(a_evict_not_hit, clock, reset, (rsp_valid_ff && evict_ff) |-> !hit_ff)
   `ASSERT_NEVER(a_we_outside_set, clock, reset, ram_we && (state_ff != arpc_pkg::BS_FINISH))
   `ASSERT_AT(a_scan_ends, clock, reset, ((state_ff == arpc_pkg::BS_SCAN) && scan_last) |=> (state_ff == arpc_pkg::BS_FINISH))
   `ASSERT_AT(a_pop_only_idle, clock, reset, item_pop |-> (item_valid && (state_ff == arpc_pkg::BS_IDLE)))

endmodule

### rtl/arp_cache_table.sv
// ARP cache with CACHE_ENTRIES slots mapping IPv4 to MAC addresses; a beat is
// a lookup, a set or an age sweep; action code 3 is a no-op. In the back end the
// entry store has one read port and is walked one entry per cycle, then the finish
// state, once the response register is free, writes a set back and loads the
// response register. A two-beat queue in front keeps accepting requests until it
// is full while the walk runs. No clearing pass is needed after reset; the valid
// bits clear at once. Depends on arpc_pkg, arpc_front, arpc_back, arpc_ram.
module arp_cache_table #(
   parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_ip_address,
   input  logic [47:0] req_mac_address,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [47:0] rsp_mac_address_out,
   output logic [2:0]  rsp_slot_index,
   output logic        rsp_evicted_valid,
   output logic [3:0]  rsp_expired_count,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic               item_valid;
   logic               item_pop;
   arpc_pkg::item_type item;

   arpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_ip_address  (req_ip_address),
      .req_mac_address (req_mac_address),
      .req_now_seconds (req_now_seconds),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   arpc_back #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .item_valid          (item_valid),
      .item                (item),
      .item_pop            (item_pop),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_mac_address_out (rsp_mac_address_out),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_evicted_valid   (rsp_evicted_valid),
      .rsp_expired_count   (rsp_expired_count)
   );

endmodule

### tb/arp_cache_table_tb.sv
// Self-checking bench for the ARP cache: directed table, then random traffic.
// Depends on arpc_pkg and arp_cache_table; expected responses come from a local cache model.
module arp_cache_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 8;
   localparam int SETTLE = 40;
   localparam longint CYCLE_LIMIT = 400000;

   // The one action code that the block leaves unused.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct packed {
      logic        hit;
      logic [47:0] mac;
      logic [2:0]  slot;
      logic        evicted;
      logic [3:0]  expired;
   } rsp_type;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [31:0] now;
      bit          fixed;
      rsp_type     want;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_wr_en = 0;
   logic [1:0] req_action = 0;
   logic [31:0] req_ip_address = 0, req_now_seconds = 0, csr_wr_data = 0;
   logic [47:0] req_mac_address = 0;
   logic req_ready, rsp_valid, rsp_hit, rsp_evicted_valid;
   logic [47:0] rsp_mac_address_out;
   logic [2:0] rsp_slot_index;
   logic [3:0] rsp_expired_count;

   arp_cache_table dut (.*);

   // Model state of the cache.
   bit          m_valid [NSLOT];
   logic [31:0] m_ip [NSLOT];
   logic [47:0] m_mac [NSLOT];
   logic [31:0] m_stamp [NSLOT];
   logic [31:0] m_timeout;

   rsp_type pending_rsp [$];
   int errors = 0, n_rsp = 0, n_evict = 0, n_expire = 0;
   int send_idle = 0, recv_idle = 0;
   int hold_off = 0;
   longint cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic rsp_type predict_cache(logic [1:0] act, logic [31:0] ip,
                                             logic [47:0] mac, logic [31:0] now);
      rsp_type r;
      int s;
      r = '0;
      s = -1;
      for (int i = 0; i < NSLOT; i++)
         if (s < 0 && m_valid[i] && m_ip[i] == ip) s = i;
      if (act == arpc_pkg::ACT_LOOKUP) begin
         if (s >= 0) begin
            r.hit = 1; r.mac = m_mac[s]; r.slot = 3'(s);
         end
      end else if (act == arpc_pkg::ACT_SET) begin
         if (s >= 0) r.hit = 1;
         else begin
            for (int i = 0; i < NSLOT; i++)
               if (s < 0 && !m_valid[i]) s = i;
            if (s < 0) begin
               s = 0;
               for (int i = 1; i < NSLOT; i++)
                  if (m_stamp[i] < m_stamp[s]) s = i;
               r.evicted = 1;
            end
         end
         m_valid[s] = 1; m_ip[s] = ip; m_mac[s] = mac; m_stamp[s] = now;
         r.slot = 3'(s);
      end else if (act == arpc_pkg::ACT_SWEEP) begin
         for (int i = 0; i < NSLOT; i++)
            if (m_valid[i] && 32'(now - m_stamp[i]) > m_timeout) begin
               m_valid[i] = 0;
               if (r.expired < 15) r.expired++;
            end
      end
      return r;
   endfunction

   // Response beats are checked against the oldest expectation.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_type got, want;
         got = {rsp_hit, rsp_mac_address_out, rsp_slot_index,
                rsp_evicted_valid, rsp_expired_count};
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %h actual %h", $time, want, got);
               errors++;
            end
            if (got.evicted) n_evict++;
            n_expire += got.expired;
         end
      end
   end

   // Receiver stalls: random, plus a long counted hold-off on request.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Valid drops only while the sender idles or drains, so each edge sees one drive.
   task automatic send_beat(logic [1:0] act, logic [31:0] ip, logic [47:0] mac,
                            logic [31:0] now, bit fixed, rsp_type want);
      rsp_type p;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_action <= act; req_ip_address <= ip;
      req_mac_address <= mac; req_now_seconds <= now;
      do @(posedge clock); while (!req_ready);
      p = predict_cache(act, ip, mac, now);
      if (fixed && p !== want) begin
         $display("%0t: table row disagrees, expected %h model %h", $time, want, p);
         errors++;
      end
      pending_rsp.push_back(p);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_timeout(logic [31:0] v);
      csr_wr_en <= 1; csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      m_timeout = v;
   endtask

   function automatic logic [31:0] pick_ip();
      // A small pool so lookups hit and sets collide.
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'hFFFF_FFFF;
         default: return 32'h0A00_0000 | $urandom_range(11);
      endcase
   endfunction

   task automatic random_burst(int n, logic [31:0] base);
      logic [31:0] now;
      logic [1:0] act;
      now = base;
      for (int k = 0; k < n; k++) begin
         now += $urandom_range(60);
         case ($urandom_range(19))
            0: act = ACT_UNUSED;
            1, 2: act = arpc_pkg::ACT_SWEEP;
            3, 4, 5, 6, 7, 8, 9: act = arpc_pkg::ACT_SET;
            default: act = arpc_pkg::ACT_LOOKUP;
         endcase
         if ($urandom_range(49) == 0) now = $urandom();
         send_beat(act, pick_ip(), 48'({$urandom(), $urandom()}), now, 0, '0);
      end
   endtask

   row_type rows [$];

   initial begin
      m_timeout = arpc_pkg::TIMEOUT_RESET;
      for (int i = 0; i < NSLOT; i++) m_valid[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed table: extremes, every action, eviction and sweep cases.
      rows.push_back('{arpc_pkg::ACT_LOOKUP, 32'h0, 48'h0, 32'h0, 1, '0});
      rows.push_back('{arpc_pkg::ACT_SWEEP, 32'h0, 48'h0, 32'hFFFF_FFFF, 1, '0});
      rows.push_back('{ACT_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1,
                       '0});
      rows.push_back('{arpc_pkg::ACT_SET, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd100, 1,
                       '{0, 48'h0, 3'd0, 0, 4'd0}});
      rows.push_back('{arpc_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0, 32'd0, 1,
                       '{1, 48'hFFFF_FFFF_FFFF, 3'd0, 0, 4'd0}});
      rows.push_back('{arpc_pkg::ACT_SET, 32'hFFFF_FFFF, 48'h0123_4567_89AB, 32'd50, 1,
                       '{1, 48'h0, 3'd0, 0, 4'd0}});
      for (int i = 1; i < 8; i++)
         rows.push_back('{arpc_pkg::ACT_SET, 32'h0A00_0000 + i, 48'hA5A5_0000_0000 + i,
                          32'd1000 - 10 * i, 0, '0});
      rows.push_back('{arpc_pkg::ACT_SET, 32'h0, 48'h5A5A_5A5A_5A5A, 32'hFFFF_FFFF, 1,
                       '{0, 48'h0, 3'd0, 1, 4'd0}});
      rows.push_back('{arpc_pkg::ACT_SET, 32'h1234_5678, 48'h1, 32'd0, 0, '0});
      rows.push_back('{arpc_pkg::ACT_LOOKUP, 32'h0A00_0003, 48'h0, 32'd0, 0, '0});
      rows.push_back('{arpc_pkg::ACT_LOOKUP, 32'h0BAD_0000, 48'h0, 32'd0, 1, '0});
      rows.push_back('{arpc_pkg::ACT_SWEEP, 32'h0, 48'h0, 32'd1290, 0, '0});
      rows.push_back('{arpc_pkg::ACT_SWEEP, 32'h0, 48'h0, 32'h8000_0000, 0, '0});
      foreach (rows[i])
         send_beat(rows[i].action, rows[i].ip, rows[i].mac, rows[i].now,
                   rows[i].fixed, rows[i].want);
      drain();

      // Random phases under varying timeouts and idling mixes.
      write_timeout(32'd0);
      send_idle = 19; recv_idle = 68;
      random_burst(300, 32'd5000);
      drain();
      write_timeout(32'hFFFF_FFFF);
      send_idle = 68; recv_idle = 19;
      random_burst(300, 32'hFFFF_F000);
      drain();
      write_timeout(32'd120);
      send_idle = 0; recv_idle = 0;
      random_burst(300, $urandom());
      // Long receiver hold-off while requests keep coming.
      hold_off = 300;
      random_burst(60, 32'd9000);
      drain();
      write_timeout(arpc_pkg::TIMEOUT_RESET);
      random_burst(370, 32'd20000);
      drain();

      $display("Covered %0d responses, %0d evictions, %0d swept entries,", n_rsp,
               n_evict, n_expire);
      $display("over four timeout settings and three idling mixes.");
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
